/* design/gsr_pkg.sv */
// Package for the grid sensing range walk core.
// Holds codes, field widths, defaults and the queue control struct; no dependencies.
package gsr_pkg;

  // Default cell capacity
  localparam int GridCellsDef = 4096;

  // Fixed field widths
  localparam int FuncW  = 2;
  localparam int IdxW   = 12;
  localparam int DimW   = 13;
  localparam int DepW   = 12;
  localparam int CountW = 13;
  localparam int CfgIdxW = 2;

  localparam logic [CountW-1:0] CountMax = {CountW{1'b1}};

  // Item function codes
  localparam logic [FuncW-1:0] FuncLoad = 2'd0;
  localparam logic [FuncW-1:0] FuncRun  = 2'd1;
  localparam logic [FuncW-1:0] FuncRead = 2'd2;

  // Result kinds
  localparam logic KindRun  = 1'b0;
  localparam logic KindRead = 1'b1;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] RegWidth  = 2'd0;
  localparam logic [CfgIdxW-1:0] RegHeight = 2'd1;
  localparam logic [CfgIdxW-1:0] RegRange  = 2'd2;

  localparam logic [DimW-1:0] WidthReset  = 13'd64;
  localparam logic [DimW-1:0] HeightReset = 13'd64;
  localparam logic [DepW-1:0] RangeReset  = 12'd0;

  // Frontier queue control
  typedef struct packed {
    logic clear;
    logic push;
    logic pop;
  } gsr_qctl_t;

endpackage

/* design/grid_sensing_range_bfs_core.sv */
// Top level of the depth-limited multi-source grid walk.
// Depends on gsr_pkg and gsr_queue; holds the cell maps as synchronous memories.
//
//   channel | direction | handshake          | payload
//   in_     | into core | in_valid/in_stall  | func, cell_index, cell_free, cell_seed
//   out_    | out       | out_valid/out_stall| result_kind, observed, observer_count
//   cfg_    | into core | cfg_valid/cfg_ready| cfg_index, cfg_data
//
// Loads can follow one another without a gap; a read's answer is registered in rd_pend_r,
// then out_valid_r. A run sweeps all GRID_CELLS cells, clearing the observed bit of each
// and the seen bit of all but the active seed cells, which it marks seen and queues; each
// walked cell then passes S_POP, S_ENT and S_OBS, each neighbour S_NB and, if it exists,
// S_NBW. After reset the free and seed map is cleared cell by cell; in_stall is high
// meanwhile. in_stall is also high while a run or read is in progress or a result waits,
// and in the cycle after a configuration write while the cell count settles.
module grid_sensing_range_bfs_core #(
  parameter int GRID_CELLS = gsr_pkg::GridCellsDef
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [gsr_pkg::FuncW-1:0]   in_func,
  input  logic [gsr_pkg::IdxW-1:0]    in_cell_index,
  input  logic                        in_cell_free,
  input  logic                        in_cell_seed,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic                        out_result_kind,
  output logic                        out_observed,
  output logic [gsr_pkg::CountW-1:0]  out_observer_count,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [gsr_pkg::CfgIdxW-1:0] cfg_index,
  input  logic [gsr_pkg::DimW-1:0]    cfg_data
);
  import gsr_pkg::*;

  localparam int CW  = $clog2(GRID_CELLS);
  localparam int AW  = ((CW > DimW) ? CW : DimW) + 1;
  localparam int PW  = 2 * DimW;
  localparam int EW  = 3 * CW + DepW;

  localparam logic [2:0] S_INIT = 3'd0;
  localparam logic [2:0] S_IDLE = 3'd1;
  localparam logic [2:0] S_SWP  = 3'd2;
  localparam logic [2:0] S_POP  = 3'd3;
  localparam logic [2:0] S_ENT  = 3'd4;
  localparam logic [2:0] S_OBS  = 3'd5;
  localparam logic [2:0] S_NB   = 3'd6;
  localparam logic [2:0] S_NBW  = 3'd7;

  // Configuration
  logic [DimW-1:0] width_r, height_r;
  logic [DepW-1:0] range_r;
  logic [AW-1:0]   n_r;
  logic [PW-1:0]   prod;
  logic            cfg_hold_r;

  assign cfg_ready = 1'b1;
  assign prod = PW'(width_r) * PW'(height_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r    <= WidthReset;
      height_r   <= HeightReset;
      range_r    <= RangeReset;
      n_r        <= '0;
      cfg_hold_r <= 1'b0;
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          RegWidth:  width_r  <= cfg_data;
          RegHeight: height_r <= cfg_data;
          RegRange:  range_r  <= cfg_data[DepW-1:0];
          default: ;
        endcase
      end
      cfg_hold_r <= cfg_valid;
      n_r <= (prod > PW'(GRID_CELLS)) ? AW'(GRID_CELLS) : AW'(prod);
    end
  end

  // Control registers
  logic [2:0]        state_r, state_nxt;
  logic [CW:0]       sc_r, sc_nxt;
  logic [CW-1:0]     srow_r, srow_nxt, scol_r, scol_nxt;
  logic              sv_r, sv_nxt;
  logic              sv_in_r;
  logic [CW-1:0]     sv_cell_r, sv_row_r, sv_col_r;
  logic [CW-1:0]     cur_cell_r, cur_row_r, cur_col_r;
  logic [DepW-1:0]   cur_dep_r;
  logic [CW-1:0]     nb_cell_r, nb_row_r, nb_col_r;
  logic [1:0]        dir_r, dir_nxt;
  logic [CountW-1:0] count_r, count_nxt;
  logic              ran_r, ran_nxt;
  logic              rd_pend_r, rd_ok_r;
  logic              out_valid_r, out_valid_nxt;
  logic              out_kind_r, out_obs_r;
  logic [CountW-1:0] out_count_r;

  // Memories: free/seed bits and seen/observed bits
  logic [1:0]    fs_mem [GRID_CELLS];
  logic [1:0]    st_mem [GRID_CELLS];
  logic [1:0]    fs_rdata_r, st_rdata_r;
  logic          fs_we, st_we;
  logic [CW-1:0] fs_wa, fs_ra, st_wa, st_ra;
  logic [1:0]    fs_wd, st_wd;

  always_ff @(posedge clk) begin
    if (fs_we) fs_mem[fs_wa] <= fs_wd;
    fs_rdata_r <= fs_mem[fs_ra];
  end

  always_ff @(posedge clk) begin
    if (st_we) st_mem[st_wa] <= st_wd;
    st_rdata_r <= st_mem[st_ra];
  end

  // Queue
  gsr_qctl_t   qctl;
  logic [EW-1:0] q_wd, q_rd;
  logic          q_empty;

  gsr_queue #(.DEPTH(GRID_CELLS), .DATA_W(EW)) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (qctl),
    .push_data(q_wd),
    .empty    (q_empty),
    .pop_data (q_rd)
  );

  // Input side
  logic          in_xfer;
  logic [AW-1:0] idx_ext;
  logic          idx_in;

  assign in_stall = (state_r != S_IDLE) || rd_pend_r || out_valid_r || cfg_hold_r;
  assign in_xfer  = in_valid && !in_stall;
  assign idx_ext  = AW'(in_cell_index);
  assign idx_in   = idx_ext < n_r;

  // Neighbour of the current cell in direction dir_r
  logic [AW-1:0] here_w, wid_w, nb_w;
  logic          nb_ok;
  logic [CW-1:0] nb_row, nb_col;

  assign here_w = AW'(cur_cell_r);
  assign wid_w  = AW'(width_r);

  always_comb begin
    nb_w   = here_w;
    nb_ok  = 1'b0;
    nb_row = cur_row_r;
    nb_col = cur_col_r;
    case (dir_r)
      2'd0: begin
        nb_ok  = (cur_row_r != '0);
        nb_w   = here_w - wid_w;
        nb_row = cur_row_r - CW'(1);
      end
      2'd1: begin
        nb_ok  = (AW'(cur_row_r) + AW'(1)) < AW'(height_r);
        nb_w   = here_w + wid_w;
        nb_row = cur_row_r + CW'(1);
      end
      2'd2: begin
        nb_ok  = (cur_col_r != '0);
        nb_w   = here_w - AW'(1);
        nb_col = cur_col_r - CW'(1);
      end
      default: begin
        nb_ok  = (AW'(cur_col_r) + AW'(1)) < wid_w;
        nb_w   = here_w + AW'(1);
        nb_col = cur_col_r + CW'(1);
      end
    endcase
    nb_ok = nb_ok && (nb_w < n_r);
  end

  // Sequencer
  always_comb begin
    state_nxt     = state_r;
    sc_nxt        = sc_r;
    srow_nxt      = srow_r;
    scol_nxt      = scol_r;
    sv_nxt        = 1'b0;
    dir_nxt       = dir_r;
    count_nxt     = count_r;
    ran_nxt       = ran_r;
    out_valid_nxt = out_valid_r && out_stall;
    fs_we = 1'b0;  fs_wa = sc_r[CW-1:0];  fs_wd = 2'b00;  fs_ra = sc_r[CW-1:0];
    st_we = 1'b0;  st_wa = sv_cell_r;     st_wd = 2'b00;  st_ra = idx_ext[CW-1:0];
    qctl  = '0;
    q_wd  = {nb_cell_r, nb_row_r, nb_col_r, cur_dep_r + DepW'(1)};
    case (state_r)
      S_INIT: begin
        fs_we = 1'b1;
        sc_nxt = sc_r + (CW+1)'(1);
        if (sc_r == (CW+1)'(GRID_CELLS - 1)) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        fs_wa = idx_ext[CW-1:0];
        fs_wd = {in_cell_free, in_cell_seed};
        if (in_xfer) begin
          case (in_func)
            FuncLoad: fs_we = idx_in;
            FuncRun: begin
              state_nxt = S_SWP;
              sc_nxt = '0;  srow_nxt = '0;  scol_nxt = '0;
              count_nxt = '0;
              qctl.clear = 1'b1;
            end
            default: ;
          endcase
        end
      end
      S_SWP: begin
        // stage two: clear every cell, mark and queue the seeds of active cells
        if (sv_r) begin
          st_we = 1'b1;
          st_wd = {fs_rdata_r[0] && sv_in_r, 1'b0};
          qctl.push = fs_rdata_r[0] && sv_in_r;
          q_wd = {sv_cell_r, sv_row_r, sv_col_r, DepW'(0)};
        end
        // stage one: read free/seed bits
        if (sc_r < (CW+1)'(GRID_CELLS)) begin
          sv_nxt = 1'b1;
          sc_nxt = sc_r + (CW+1)'(1);
          if ((AW'(scol_r) + AW'(1)) == wid_w) begin
            scol_nxt = '0;
            srow_nxt = srow_r + CW'(1);
          end else begin
            scol_nxt = scol_r + CW'(1);
          end
        end else if (!sv_r) begin
          state_nxt = S_POP;
        end
      end
      S_POP: begin
        if (q_empty) begin
          out_valid_nxt = 1'b1;
          ran_nxt = 1'b1;
          state_nxt = S_IDLE;
        end else begin
          qctl.pop = 1'b1;
          state_nxt = S_ENT;
        end
      end
      S_ENT: begin
        fs_ra = q_rd[EW-1 -: CW];
        state_nxt = S_OBS;
      end
      S_OBS: begin
        st_we = 1'b1;
        st_wa = cur_cell_r;
        st_wd = {1'b1, fs_rdata_r[1]};
        if (fs_rdata_r[1] && count_r != CountMax) count_nxt = count_r + CountW'(1);
        dir_nxt = 2'd0;
        state_nxt = (cur_dep_r >= range_r) ? S_POP : S_NB;
      end
      S_NB: begin
        st_ra = nb_w[CW-1:0];
        if (nb_ok) begin
          state_nxt = S_NBW;
        end else if (dir_r == 2'd3) begin
          state_nxt = S_POP;
        end else begin
          dir_nxt = dir_r + 2'd1;
        end
      end
      S_NBW: begin
        st_wa = nb_cell_r;
        st_wd = 2'b10;
        if (!st_rdata_r[1]) begin
          st_we = 1'b1;
          qctl.push = 1'b1;
        end
        if (dir_r == 2'd3) begin
          state_nxt = S_POP;
        end else begin
          dir_nxt = dir_r + 2'd1;
          state_nxt = S_NB;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
    if (rd_pend_r) out_valid_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_INIT;
      sc_r        <= '0;
      sv_r        <= 1'b0;
      dir_r       <= 2'd0;
      count_r     <= '0;
      ran_r       <= 1'b0;
      rd_pend_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      sc_r        <= sc_nxt;
      sv_r        <= sv_nxt;
      dir_r       <= dir_nxt;
      count_r     <= count_nxt;
      ran_r       <= ran_nxt;
      rd_pend_r   <= in_xfer && (in_func == FuncRead);
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    srow_r    <= srow_nxt;
    scol_r    <= scol_nxt;
    sv_cell_r <= sc_r[CW-1:0];
    sv_in_r   <= (AW'(sc_r) < n_r);
    sv_row_r  <= srow_r;
    sv_col_r  <= scol_r;
    rd_ok_r   <= ran_r && idx_in;
    if (state_r == S_ENT) begin
      {cur_cell_r, cur_row_r, cur_col_r, cur_dep_r} <= q_rd;
    end
    if (state_r == S_NB) begin
      nb_cell_r <= nb_w[CW-1:0];
      nb_row_r  <= nb_row;
      nb_col_r  <= nb_col;
    end
    if (rd_pend_r) begin
      out_kind_r  <= KindRead;
      out_obs_r   <= rd_ok_r && st_rdata_r[0];
      out_count_r <= count_r;
    end else if (state_r == S_POP && q_empty) begin
      out_kind_r  <= KindRun;
      out_obs_r   <= 1'b0;
      out_count_r <= count_r;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_result_kind    = out_kind_r;
  assign out_observed       = out_obs_r;
  assign out_observer_count = out_count_r;

endmodule

/* design/gsr_queue.sv */
// Frontier queue of the walk: a FIFO held in one synchronous memory.
// Uses gsr_pkg for the control struct. Read data appears in the cycle after pop.
module gsr_queue #(
  parameter int DEPTH  = 4096,
  parameter int DATA_W = 48
) (
  input  logic              clk,
  input  logic              rst_n,
  input  gsr_pkg::gsr_qctl_t ctl,
  input  logic [DATA_W-1:0] push_data,
  output logic              empty,
  output logic [DATA_W-1:0] pop_data
);
  import gsr_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int PW = AW + 1;

  logic [DATA_W-1:0] mem [DEPTH];
  logic [PW-1:0]     head_r, head_nxt;
  logic [PW-1:0]     tail_r, tail_nxt;
  logic              full;
  logic              do_push;
  logic [DATA_W-1:0] rdata_r;

  assign full     = (tail_r == PW'(DEPTH));
  assign empty    = (head_r == tail_r);
  assign do_push  = ctl.push && !full;
  assign pop_data = rdata_r;

  // Pointer update
  always_comb begin
    head_nxt = head_r;
    tail_nxt = tail_r;
    if (ctl.clear) begin
      head_nxt = '0;
      tail_nxt = '0;
    end else begin
      if (ctl.pop && !empty) head_nxt = head_r + PW'(1);
      if (do_push) tail_nxt = tail_r + PW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r <= '0;
      tail_r <= '0;
    end else begin
      head_r <= head_nxt;
      tail_r <= tail_nxt;
    end
  end

  // Storage: one write, one registered read
  always_ff @(posedge clk) begin
    if (do_push && !ctl.clear) mem[tail_r[AW-1:0]] <= push_data;
    rdata_r <= mem[head_r[AW-1:0]];
  end

endmodule

/* verif/grid_sensing_range_bfs_checker.sv */
// Checker for grid_sensing_range_bfs_core: watches the config, input and result channels.
// Predicts each run and read answer from its own copy of the maps; depends on gsr_pkg.
module grid_sensing_range_bfs_checker (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  input  logic                        in_stall,
  input  logic [gsr_pkg::FuncW-1:0]   in_func,
  input  logic [gsr_pkg::IdxW-1:0]    in_cell_index,
  input  logic                        in_cell_free,
  input  logic                        in_cell_seed,
  input  logic                        out_valid,
  input  logic                        out_stall,
  input  logic                        out_result_kind,
  input  logic                        out_observed,
  input  logic [gsr_pkg::CountW-1:0]  out_observer_count,
  input  logic                        cfg_valid,
  input  logic                        cfg_ready,
  input  logic [gsr_pkg::CfgIdxW-1:0] cfg_index,
  input  logic [gsr_pkg::DimW-1:0]    cfg_data,
  output int                          fail_count,
  output int                          pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import gsr_pkg::*;

  localparam int Cells = GridCellsDef;

  typedef struct packed {
    logic              kind;
    logic              observed;
    logic [CountW-1:0] count;
  } answer_t;

  // Predicted block state
  bit              free_m [Cells];
  bit              seed_m [Cells];
  bit              obs_m  [Cells];
  bit              seen_m [Cells];
  int unsigned     wave_cell [Cells];
  int unsigned     wave_dep  [Cells];
  logic [DimW-1:0] grid_w, grid_h;
  logic [DepW-1:0] sense_range;
  logic [CountW-1:0] observers;
  answer_t         answers_due [$];

  function automatic int unsigned live_cells();
    int unsigned n;
    n = grid_w * grid_h;
    return (n > Cells) ? Cells : n;
  endfunction

  // Append one predicted answer
  function automatic void queue_answer(answer_t a);
    answers_due = {answers_due, a};
  endfunction

  // Multi-source walk, depth-limited; blocked cells are walked through but not counted
  function automatic void sweep_observed();
    int unsigned n, head, tail, here, dep, r, c, nxt;
    int d;
    n = live_cells();
    head = 0;
    tail = 0;
    observers = '0;
    for (int i = 0; i < Cells; i++) begin
      seen_m[i] = 0;
      obs_m[i] = 0;
    end
    for (int unsigned i = 0; i < n; i++) begin
      if (seed_m[i]) begin
        seen_m[i] = 1;
        wave_cell[tail] = i;
        wave_dep[tail] = 0;
        tail++;
      end
    end
    while (head < tail) begin
      here = wave_cell[head];
      dep = wave_dep[head];
      head++;
      if (free_m[here] && !obs_m[here]) begin
        obs_m[here] = 1;
        if (observers != CountMax) observers++;
      end
      if (dep < sense_range) begin
        r = here / grid_w;
        c = here % grid_w;
        for (d = 0; d < 4; d++) begin
          // up, down, left, right
          if (d == 0 && r == 0) continue;
          if (d == 1 && r + 1 >= grid_h) continue;
          if (d == 2 && c == 0) continue;
          if (d == 3 && c + 1 >= grid_w) continue;
          case (d)
            0: nxt = here - grid_w;
            1: nxt = here + grid_w;
            2: nxt = here - 1;
            default: nxt = here + 1;
          endcase
          if (nxt >= n || seen_m[nxt] || tail >= Cells) continue;
          seen_m[nxt] = 1;
          wave_cell[tail] = nxt;
          wave_dep[tail] = dep + 1;
          tail++;
        end
      end
    end
  endfunction

  function automatic void check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $display("%0t ns: %s expected %0d actual %0d", $time, name, want, got);
      fail_count++;
    end
  endfunction

  // Track transfers on all three channels
  always @(posedge clk) begin
    answer_t want;
    if (!rst_n) begin
      for (int i = 0; i < Cells; i++) begin
        free_m[i] = 0;
        seed_m[i] = 0;
        obs_m[i] = 0;
      end
      grid_w = WidthReset;
      grid_h = HeightReset;
      sense_range = RangeReset;
      observers = '0;
      answers_due.delete();
      fail_count = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          RegWidth:  grid_w = cfg_data;
          RegHeight: grid_h = cfg_data;
          RegRange:  sense_range = cfg_data[DepW-1:0];
          default: ;
        endcase
      end
      if (out_valid && !out_stall) begin
        if (answers_due.size() == 0) begin
          $display("%0t ns: result transfer with none expected (kind %0d count %0d)",
                   $time, out_result_kind, out_observer_count);
          fail_count++;
        end else begin
          want = answers_due.pop_front();
          check_field("result_kind", want.kind, out_result_kind);
          check_field("observed", want.observed, out_observed);
          check_field("observer_count", want.count, out_observer_count);
        end
      end
      if (in_valid && !in_stall) begin
        case (in_func)
          FuncLoad: if (in_cell_index < live_cells()) begin
            free_m[in_cell_index] = in_cell_free;
            seed_m[in_cell_index] = in_cell_seed;
          end
          FuncRun: begin
            sweep_observed();
            queue_answer('{KindRun, 1'b0, observers});
          end
          FuncRead: queue_answer('{KindRead,
              (in_cell_index < live_cells()) ? obs_m[in_cell_index] : 1'b0, observers});
          default: ;
        endcase
      end
    end
    pending = answers_due.size();
  end

  initial begin
    fail_count = 0;
    pending = 0;
  end

endmodule

/* verif/grid_sensing_range_bfs_core_tb.sv */
// Testbench top for grid_sensing_range_bfs_core: drives loads, runs and reads over
// several grid settings; depends on gsr_pkg and grid_sensing_range_bfs_checker.
module grid_sensing_range_bfs_core_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import gsr_pkg::*;

  localparam logic [FuncW-1:0] FuncSpare = 2'd3;
  localparam int CycleLimit = 20000000;

  logic              clk, rst_n;
  logic              in_valid, in_stall, in_cell_free, in_cell_seed;
  logic [FuncW-1:0]  in_func;
  logic [IdxW-1:0]   in_cell_index;
  logic              out_valid, out_stall, out_result_kind, out_observed;
  logic [CountW-1:0] out_observer_count;
  logic              cfg_valid, cfg_ready;
  logic [CfgIdxW-1:0] cfg_index;
  logic [DimW-1:0]   cfg_data;
  int                fail_count, pending;
  int                cycles, items_sent, runs_sent, settings_done;
  int                stall_mode, burst_left;
  int unsigned       cur_w, cur_h;

  grid_sensing_range_bfs_core DUT (.*);

  grid_sensing_range_bfs_checker checker_i (.*);

  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  // Result side back-pressure on its own pattern
  always @(posedge clk) begin
    case (stall_mode)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(0, 3) == 0);
      default: out_stall <= ($urandom_range(0, 3) != 0);
    endcase
  end

  // Watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("timeout after %0d cycles", cycles);
      $display("grid_sensing_range_bfs_core: mismatch");
      $finish;
    end
  end

  // One input transfer; valid stays high afterwards, but the task may drop it for a gap
  task automatic send_item(logic [FuncW-1:0] f, logic [IdxW-1:0] idx, logic fr, logic sd);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 10);
      if (in_valid && $urandom_range(0, 2) != 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 5)) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    in_func <= f;
    in_cell_index <= idx;
    in_cell_free <= fr;
    in_cell_seed <= sd;
    do @(negedge clk); while (in_stall);
    @(posedge clk);
    items_sent++;
    if (f == FuncRun) runs_sent++;
  endtask

  task automatic cfg_write(logic [CfgIdxW-1:0] idx, logic [DimW-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(negedge clk); while (!cfg_ready);
    @(posedge clk);
  endtask

  // Drain outstanding answers, then allow for a trailing load or read
  task automatic settle();
    in_valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    repeat (16) @(posedge clk);
  endtask

  task automatic set_grid(int unsigned w, int unsigned h, int unsigned r);
    settle();
    cfg_write(RegWidth, DimW'(w));
    cfg_write(RegHeight, DimW'(h));
    cfg_write(RegRange, DimW'(r));
    cfg_valid <= 1'b0;
    cur_w = w;
    cur_h = h;
    stall_mode = $urandom_range(0, 2);
    settings_done++;
  endtask

  // Mostly loads over the live grid, mixed with runs and reads; a little noise
  task automatic random_items(int count);
    int unsigned n, pick, runs;
    logic [IdxW-1:0] idx;
    n = cur_w * cur_h;
    if (n > GridCellsDef) n = GridCellsDef;
    runs = 0;
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(0, 99);
      if (n > 0 && $urandom_range(0, 99) < 85) idx = IdxW'($urandom_range(0, n - 1));
      else idx = IdxW'($urandom);
      if (pick >= 55 && pick < 67 && n > 256 && runs >= 3) pick = 80;
      if (pick < 55)
        send_item(FuncLoad, idx, $urandom_range(0, 9) < 6, $urandom_range(0, 99) < 15);
      else if (pick < 67) begin
        send_item(FuncRun, IdxW'($urandom), 1'($urandom), 1'($urandom));
        runs++;
      end else if (pick < 95)
        send_item(FuncRead, idx, 1'($urandom), 1'($urandom));
      else
        send_item(FuncSpare, IdxW'($urandom), 1'($urandom), 1'($urandom));
    end
  endtask

  initial begin
    int unsigned w, h;
    rst_n = 0;
    in_valid = 0;
    in_func = FuncLoad;
    in_cell_index = '0;
    in_cell_free = 0;
    in_cell_seed = 0;
    out_stall = 0;
    cfg_valid = 0;
    cfg_index = RegWidth;
    cfg_data = '0;
    cycles = 0;
    items_sent = 0;
    runs_sent = 0;
    settings_done = 0;
    stall_mode = 0;
    burst_left = 0;
    cur_w = WidthReset;
    cur_h = HeightReset;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Reset settings: read before any run, corner cells, range zero, spare code
    send_item(FuncRead, 12'd0, 1'b0, 1'b0);
    send_item(FuncLoad, 12'd0, 1'b1, 1'b1);
    send_item(FuncLoad, 12'd1, 1'b1, 1'b0);
    send_item(FuncLoad, 12'd4095, 1'b1, 1'b1);
    send_item(FuncLoad, 12'd4094, 1'b0, 1'b1);
    send_item(FuncRun, 12'd0, 1'b0, 1'b0);
    send_item(FuncRead, 12'd0, 1'b0, 1'b0);
    send_item(FuncRead, 12'd1, 1'b0, 1'b0);
    send_item(FuncRead, 12'd4095, 1'b0, 1'b0);
    send_item(FuncSpare, 12'd4095, 1'b1, 1'b1);
    send_item(FuncLoad, 12'd1, 1'b1, 1'b1);
    send_item(FuncRead, 12'd1, 1'b0, 1'b0);
    random_items(30);

    // Zero width: nothing exists, loads ignored, reads answer zero
    set_grid(0, 5, 3);
    send_item(FuncLoad, 12'd2, 1'b1, 1'b1);
    send_item(FuncRun, 12'd0, 1'b0, 1'b0);
    send_item(FuncRead, 12'd2, 1'b0, 1'b0);
    send_item(FuncRead, 12'd4095, 1'b0, 1'b0);

    // Largest sizes and range
    set_grid(4096, 4096, 4095);
    random_items(40);
    set_grid(4096, 1, 4095);
    random_items(40);
    set_grid(1, 4096, 0);
    random_items(40);
    set_grid(3, 4, 4095);
    send_item(FuncLoad, 12'd11, 1'b1, 1'b0);
    send_item(FuncRead, 12'd12, 1'b0, 1'b0);
    random_items(40);

    // Small grids, assorted ranges
    for (int p = 0; p < 11; p++) begin
      w = $urandom_range(1, 12);
      h = $urandom_range(1, 12);
      set_grid(w, h, ($urandom_range(0, 7) == 0) ? $urandom_range(0, 4095)
                                                  : $urandom_range(0, w + h));
      random_items(50);
    end

    settle();
    repeat (50) @(posedge clk);
    $display("covered %0d input transfers, %0d walks, %0d grid settings",
             items_sent, runs_sent, settings_done);
    if (fail_count == 0) begin
      $display("grid_sensing_range_bfs_core: match");
    end else begin
      $display("grid_sensing_range_bfs_core: mismatch");
    end
    $finish;
  end

endmodule
